@@ hdl/kct_pkg.sv @@
// Package for the keyed counter table: sizes, entry layout and command codes.
`default_nettype none
package kct_pkg;

    // Table geometry
    localparam int ENTRIES  = 64;
    localparam int KEY_BITS = 33;
    localparam int ADDR_W   = $clog2(ENTRIES);
    localparam int OCC_W    = $clog2(ENTRIES + 1);

    // Field widths
    localparam int CNT_W = 6;
    localparam int CMD_W = 2;

    // Counter wrap mask
    localparam logic [CNT_W-1:0] CNT_MASK = 6'h3F;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_GET  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

    // One table entry as stored in the memory
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [CNT_W-1:0]    count;
    } t_entry;

endpackage
`default_nettype wire

@@ hdl/kct_if.sv @@
// Valid/ready channel interfaces for command input and result output.
`default_nettype none
interface kct_in_if import kct_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [KEY_BITS-1:0] key;
    logic [CNT_W-1:0]    new_value;

    modport source (output valid, cmd, key, new_value, input ready);
    modport sink   (input valid, cmd, key, new_value, output ready);
endinterface

interface kct_out_if import kct_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] count_value;
    logic             found;

    modport source (output valid, count_value, found, input ready);
    modport sink   (input valid, count_value, found, output ready);
endinterface
`default_nettype wire

@@ hdl/keyed_counter_table_lru.sv @@
// Keyed counter table, LRU order kept as position in memory (position 0 = most recent).
// Sequence: scan the occupied entries from the front, shift the entries ahead of the target back
//   by one and write the front entry, then load the reply (a peek miss skips the shift, a set has no reply).
// Throughput: one command at a time; input ready only while idle.
// Reset: synchronous, active low; fill count cleared, memory contents beyond it never read.
`default_nettype none
module keyed_counter_table_lru import kct_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kct_in_if.sink     i_in,
    kct_out_if.source  o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_REPLY
    } t_state;

    t_state r_state;

    // Entry memory, one read and one write port, registered read data
    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;
    logic             r_rd_ok;
    logic [ADDR_W-1:0] r_rd_pos;

    // Command latch and working registers
    logic [CMD_W-1:0]    r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [CNT_W-1:0]    r_nv;
    logic [CNT_W-1:0]    r_new_cnt;
    logic                r_found;
    logic                r_grow;
    logic [OCC_W-1:0]    r_occ;
    logic [OCC_W-1:0]    r_addr;
    logic [ADDR_W-1:0]   r_sh_addr;
    logic [OCC_W-1:0]    r_sh_rem;

    // Output register
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_cnt;
    logic             r_out_found;

    logic              w_match;
    logic              w_miss;
    logic              w_full;
    logic              w_scan_issue;
    logic              w_sh_issue;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    t_entry            w_wdata;
    logic [OCC_W-1:0]  n_sh_rem;
    logic [CNT_W-1:0]  n_new_cnt;
    logic              w_accept;

    assign i_in.ready        = (r_state == S_IDLE);
    assign w_accept          = i_in.valid && i_in.ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.count_value = r_out_cnt;
    assign o_out.found       = r_out_found;

    // Lookup compare, memory port control and shift amount
    always_comb begin
        w_full       = (r_occ == OCC_W'(ENTRIES));
        w_match      = (r_state == S_SCAN) && r_rd_ok && (r_rd_data.key == r_key);
        w_miss       = !r_rd_ok && (r_addr == r_occ);
        w_scan_issue = (r_state == S_SCAN) && (r_addr < r_occ) && !w_match;
        w_sh_issue   = (r_state == S_SHIFT) && (r_sh_rem != '0);
        w_re         = w_scan_issue || w_sh_issue;
        w_raddr      = (r_state == S_SHIFT) ? r_sh_addr : r_addr[ADDR_W-1:0];

        // Shift writes move an entry one place back; the last write fills the front
        w_we    = (r_state == S_SHIFT) && (r_rd_ok || (r_sh_rem == '0));
        w_waddr = r_rd_ok ? (r_rd_pos + ADDR_W'(1)) : '0;
        w_wdata = r_rd_ok ? r_rd_data : t_entry'{key: r_key, count: r_new_cnt};

        // Entries ahead of the target position move back by one
        if (w_match) begin
            n_sh_rem = OCC_W'(r_rd_pos);
        end else if (w_full) begin
            n_sh_rem = OCC_W'(ENTRIES - 1);
        end else begin
            n_sh_rem = r_occ;
        end

        // Counter value written to the front entry
        case (r_cmd)
            CMD_GET:  n_new_cnt = w_match ? ((r_rd_data.count + CNT_W'(1)) & CNT_MASK)
                                          : CNT_W'(1);
            CMD_PEEK: n_new_cnt = w_match ? r_rd_data.count : '0;
            CMD_SET:  n_new_cnt = r_nv;
            default:  n_new_cnt = '0;
        endcase
    end

    // Memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // Control state machine and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ok     <= 1'b0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_ok  <= w_re;
            r_rd_pos <= w_raddr;

            // Output register empties on transfer; a new reply load covers it in S_REPLY
            if (r_out_valid && o_out.ready && (r_state != S_REPLY)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_in.cmd != CMD_NOP)) begin
                        r_cmd   <= i_in.cmd;
                        r_key   <= i_in.key;
                        r_nv    <= i_in.new_value & CNT_MASK;
                        r_addr  <= '0;
                        r_state <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    if (w_scan_issue) begin
                        r_addr <= r_addr + OCC_W'(1);
                    end
                    if (w_match) begin
                        r_found   <= 1'b1;
                        r_grow    <= 1'b0;
                        r_new_cnt <= n_new_cnt;
                        r_sh_rem  <= n_sh_rem;
                        r_sh_addr <= ADDR_W'(n_sh_rem - OCC_W'(1));
                        r_state   <= S_SHIFT;
                    end else if (w_miss) begin
                        r_found   <= 1'b0;
                        r_grow    <= !w_full;
                        r_new_cnt <= n_new_cnt;
                        r_sh_rem  <= n_sh_rem;
                        r_sh_addr <= ADDR_W'(n_sh_rem - OCC_W'(1));
                        // Peek miss leaves the table alone
                        r_state   <= (r_cmd == CMD_PEEK) ? S_REPLY : S_SHIFT;
                    end
                end

                S_SHIFT: begin
                    if (w_sh_issue) begin
                        r_sh_addr <= r_sh_addr - ADDR_W'(1);
                        r_sh_rem  <= r_sh_rem - OCC_W'(1);
                    end
                    // Front write this cycle finishes the move
                    if ((r_sh_rem == '0) && !r_rd_ok) begin
                        if (r_grow) begin
                            r_occ <= r_occ + OCC_W'(1);
                        end
                        r_state <= (r_cmd == CMD_SET) ? S_IDLE : S_REPLY;
                    end
                end

                S_REPLY: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_cnt   <= r_new_cnt;
                        r_out_found <= r_found;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ tb/tb_keyed_counter_table_lru.sv @@
// Testbench for keyed_counter_table_lru: directed and random commands checked against an LRU model.
`default_nettype none
module tb_keyed_counter_table_lru;
    import kct_pkg::*;

    // Run shape
    localparam int PHASE_ITEMS     = 460;
    localparam int PRESSURE_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 2 * ENTRIES + 16;
    localparam int STALL_LIMIT     = 4000;
    localparam int DIR_ROWS        = 19;

    localparam logic [KEY_BITS-1:0] KEY_MAX = {KEY_BITS{1'b1}};

    typedef struct packed {
        logic [CNT_W-1:0] count_value;
        logic             found;
    } t_reply;

    // One directed step; reply fields only meaningful when has_reply is set
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [KEY_BITS-1:0] key;
        logic [CNT_W-1:0]    new_value;
        logic                has_reply;
        logic [CNT_W-1:0]    count_value;
        logic                found;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    kct_in_if  cmd_ch ();
    kct_out_if res_ch ();

    keyed_counter_table_lru uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch.sink),
        .o_out   (res_ch.source)
    );

    // Recency list of the model, most recently used entry first
    t_entry   lru_list[$];
    t_reply   pending_replies[$];
    t_dir_row dir_rows[DIR_ROWS];

    int error_count   = 0;
    int send_idle_pct = 9;
    int recv_idle_pct = 61;
    int phase         = 0;
    int hold_left     = 0;
    bit pressure_done = 0;
    int quiet_cycles  = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Model of one command: updates the recency list, returns the reply if any
    function automatic void predict_command(input logic [CMD_W-1:0] cmd,
                                            input logic [KEY_BITS-1:0] key,
                                            input logic [CNT_W-1:0] new_value,
                                            output bit has_reply,
                                            output t_reply reply);
        int     pos;
        t_entry ent;
        pos       = -1;
        has_reply = 0;
        reply     = '0;
        foreach (lru_list[i])
            if (lru_list[i].key == key) pos = i;
        case (cmd)
            CMD_GET: begin
                if (pos >= 0) begin
                    ent = lru_list[pos];
                    lru_list.delete(pos);
                    ent.count = (ent.count + 1'b1) & CNT_MASK;
                end else begin
                    if (lru_list.size() >= ENTRIES) void'(lru_list.pop_back());
                    ent.key   = key;
                    ent.count = 1;
                end
                lru_list.push_front(ent);
                has_reply = 1;
                reply     = '{count_value: ent.count, found: (pos >= 0)};
            end
            CMD_PEEK: begin
                has_reply = 1;
                if (pos >= 0) begin
                    ent = lru_list[pos];
                    lru_list.delete(pos);
                    lru_list.push_front(ent);
                    reply = '{count_value: ent.count, found: 1'b1};
                end
            end
            CMD_SET: begin
                if (pos >= 0)
                    lru_list.delete(pos);
                else if (lru_list.size() >= ENTRIES)
                    void'(lru_list.pop_back());
                ent.key   = key;
                ent.count = new_value;
                lru_list.push_front(ent);
            end
            default: ;
        endcase
    endfunction

    // Offer one command, wait for its transfer, then record the expected reply
    task automatic offer_command(input logic [CMD_W-1:0] cmd,
                                 input logic [KEY_BITS-1:0] key,
                                 input logic [CNT_W-1:0] new_value,
                                 input bit typed,
                                 input t_reply typed_reply);
        bit     has_reply;
        t_reply reply;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.cmd       <= cmd;
        cmd_ch.key       <= key;
        cmd_ch.new_value <= new_value;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predict_command(cmd, key, new_value, has_reply, reply);
        if (has_reply) pending_replies.push_back(typed ? typed_reply : reply);
    endtask

    // Receiver: random stalls, plus one long hold-off at the start of the last phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else if (phase == 2 && !pressure_done) begin
            hold_left     <= PRESSURE_CYCLES;
            pressure_done <= 1'b1;
            res_ch.ready  <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Reply checker
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected reply: count_value %0d found %0d",
                       res_ch.count_value, res_ch.found);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (res_ch.count_value !== want.count_value) begin
                    $error("count_value mismatch: expected %0d, actual %0d",
                           want.count_value, res_ch.count_value);
                    error_count++;
                end
                if (res_ch.found !== want.found) begin
                    $error("found mismatch: expected %0d, actual %0d",
                           want.found, res_ch.found);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        logic [KEY_BITS-1:0] key_pool[$];
        logic [63:0]         wide;
        logic [KEY_BITS-1:0] key;
        logic [CMD_W-1:0]    cmd;
        int                  pick;
        int                  pool_size;

        i_rst_n          = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.cmd       = CMD_NOP;
        cmd_ch.key       = '0;
        cmd_ch.new_value = '0;

        // Directed steps: empty table, counter wrap, ignored code, hits and misses
        dir_rows = '{
            '{CMD_PEEK, 33'h0,           6'd0,  1'b1, 6'd0,  1'b0},   // empty table
            '{CMD_GET,  33'h0,           6'd0,  1'b1, 6'd1,  1'b0},
            '{CMD_GET,  33'h0,           6'd0,  1'b1, 6'd2,  1'b1},
            '{CMD_PEEK, KEY_MAX,         6'd0,  1'b1, 6'd0,  1'b0},   // peek miss
            '{CMD_SET,  KEY_MAX,         6'd63, 1'b0, 6'd0,  1'b0},   // set miss allocates
            '{CMD_PEEK, KEY_MAX,         6'd0,  1'b1, 6'd63, 1'b1},
            '{CMD_GET,  KEY_MAX,         6'd0,  1'b1, 6'd0,  1'b1},   // counter wraps
            '{CMD_NOP,  KEY_MAX,         6'd63, 1'b0, 6'd0,  1'b0},
            '{CMD_PEEK, KEY_MAX,         6'd0,  1'b1, 6'd0,  1'b1},
            '{CMD_NOP,  33'h5,           6'd7,  1'b0, 6'd0,  1'b0},   // unused code
            '{CMD_PEEK, 33'h5,           6'd0,  1'b1, 6'd0,  1'b0},
            '{CMD_SET,  33'h0,           6'd0,  1'b0, 6'd0,  1'b0},   // set hit
            '{CMD_GET,  33'h0,           6'd0,  1'b1, 6'd1,  1'b1},
            '{CMD_SET,  33'h1_5555_5555, 6'h2A, 1'b0, 6'd0,  1'b0},
            '{CMD_GET,  33'h0_AAAA_AAAA, 6'h15, 1'b1, 6'd1,  1'b0},
            '{CMD_GET,  33'h1_5555_5555, 6'd0,  1'b1, 6'd43, 1'b1},
            '{CMD_PEEK, 33'h1_0000_0000, 6'd0,  1'b1, 6'd0,  1'b0},
            '{CMD_SET,  33'h1,           6'd1,  1'b0, 6'd0,  1'b0},
            '{CMD_PEEK, 33'h1,           6'd0,  1'b1, 6'd1,  1'b1}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            offer_command(dir_rows[r].cmd, dir_rows[r].key, dir_rows[r].new_value,
                          dir_rows[r].has_reply,
                          '{count_value: dir_rows[r].count_value, found: dir_rows[r].found});

        // Random phases; key pool a bit larger than the table so eviction is frequent
        for (int ph = 0; ph < 3; ph++) begin
            phase         = ph;
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 61 : 0;
            recv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 9 : 0;
            key_pool.delete();
            key_pool.push_back('0);
            key_pool.push_back(KEY_MAX);
            pool_size = $urandom_range(90, 66);
            while (key_pool.size() < pool_size) begin
                wide = {$urandom, $urandom};
                key_pool.push_back(wide[KEY_BITS-1:0]);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 45)      cmd = CMD_GET;
                else if (pick < 75) cmd = CMD_PEEK;
                else if (pick < 95) cmd = CMD_SET;
                else                cmd = CMD_NOP;
                if ($urandom_range(99) < 85) begin
                    key = key_pool[$urandom_range(key_pool.size() - 1)];
                end else begin
                    wide = {$urandom, $urandom};
                    key  = wide[KEY_BITS-1:0];
                end
                offer_command(cmd, key, CNT_W'($urandom_range(63)), 1'b0, '0);
            end
        end

        // Drain: every reply in, then allow for a trailing set still in flight
        cmd_ch.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
hdl/kct_pkg.sv
hdl/kct_if.sv
hdl/keyed_counter_table_lru.sv
tb/tb_keyed_counter_table_lru.sv
